// ===== hdl/u2u_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types and constants for the decoder front end, the job queue and the
// code unit serializer.
// ----------------------------------------------------------------------------
package u2u_pkg;

  // Replacement character for malformed input.
  localparam logic [15:0] ReplChar     = 16'hFFFD;
  // Scalar limits.
  localparam logic [20:0] MaxScalar    = 21'h10FFFF;
  localparam logic [20:0] SurrLow      = 21'h00D800;
  localparam logic [20:0] SurrHigh     = 21'h00DFFF;
  localparam logic [20:0] SuppBase     = 21'h010000;
  // Surrogate pair bases.
  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase  = 16'hDC00;
  // Smallest legal scalar for each sequence length.
  localparam logic [16:0] Floor2       = 17'h00080;
  localparam logic [16:0] Floor3       = 17'h00800;
  localparam logic [16:0] Floor4       = 17'h10000;

  // One decoded byte's worth of output: a run of replacement units followed
  // by zero to two data units.
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic [1:0]  data_cnt;
    logic [15:0] data0;
    logic [15:0] data1;
    logic        last;
  } job_t;

  // Queue status seen by the input handshake of the top level and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== hdl/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// A byte is decoded combinationally and written into the job queue at the
// edge that accepts it; its first unit then passes through the output register.
// Throughput: one byte per cycle while the queue has room; a byte that yields
// several units holds the output serializer until it has sent all of them.
// The job queue holds FifoDepth jobs of up to four units each; the input
// stalls only while it is full.
// Reset clears the pending sequence, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
  parameter int FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] code_unit
  output logic        m_axis_tuser,  // [0] last_of_run
  output logic        m_axis_tlast   // string_end
);

  logic                  accept;
  logic                  push;
  logic                  pop;
  u2u_pkg::job_t         job;
  u2u_pkg::job_t         head;
  u2u_pkg::fifo_status_t status;

  assign s_axis_tready = !status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decoder front end.
  u2u_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .job_o    (job)
  );

  // Job queue between the two halves.
  u2u_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  // Unit serializer and output register.
  u2u_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .status_i   (status),
    .pop_o      (pop),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .unit_o     (m_axis_tdata),
    .run_last_o (m_axis_tuser),
    .str_last_o (m_axis_tlast)
  );

  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !status.full)
    else $error("job pushed into a full queue");

  // The queue is never read while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !status.empty)
    else $error("job popped from an empty queue");

  // The final unit of a string always closes the run of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("string end without end of run");

endmodule

// ===== hdl/u2u_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts one byte per cycle when accept_i is high, tracks the pending sequence
// and turns each byte that yields code units into a job that lists them.
// ----------------------------------------------------------------------------
module u2u_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output logic           push_o,
  output u2u_pkg::job_t  job_o
);

  logic [2:0]  exp_len_q, exp_len_d;
  logic [1:0]  seen_q, seen_d;
  logic [20:0] partial_q, partial_d;
  logic [16:0] floor_q, floor_d;

  logic        pending;
  logic        is_cont;
  logic        start_en;
  logic [2:0]  rep;
  logic [20:0] value;
  logic [19:0] supp;
  logic        bad;
  u2u_pkg::job_t job;

  assign pending = (exp_len_q != 3'd0);
  assign is_cont = (byte_i[7:6] == 2'b10);
  assign value   = {partial_q[14:0], byte_i[5:0]};
  assign supp    = 20'(value - u2u_pkg::SuppBase);
  assign bad     = (value < {4'b0, floor_q}) || (value > u2u_pkg::MaxScalar) ||
                   ((value >= u2u_pkg::SurrLow) && (value <= u2u_pkg::SurrHigh));

  // Classify the byte against the pending sequence and build the job.
  always_comb begin
    exp_len_d      = exp_len_q;
    seen_d         = seen_q;
    partial_d      = partial_q;
    floor_d        = floor_q;
    job            = '0;
    job.last       = last_i;
    rep            = 3'd0;
    start_en       = 1'b0;
    if (pending) begin
      if (is_cont) begin
        if (({1'b0, seen_q} + 3'd1) >= exp_len_q) begin
          // Sequence complete: check the scalar and emit it.
          if (bad) begin
            rep = exp_len_q;
          end else if (value < u2u_pkg::SuppBase) begin
            job.data_cnt = 2'd1;
            job.data0    = value[15:0];
          end else begin
            job.data_cnt = 2'd2;
            job.data0    = u2u_pkg::HighSurrBase + {6'b0, supp[19:10]};
            job.data1    = u2u_pkg::LowSurrBase + {6'b0, supp[9:0]};
          end
          exp_len_d = '0;
          seen_d    = '0;
          partial_d = '0;
          floor_d   = '0;
        end else begin
          seen_d    = seen_q + 2'd1;
          partial_d = value;
          if (last_i) begin
            // Truncated at the end of the string.
            rep       = {1'b0, seen_q} + 3'd1;
            exp_len_d = '0;
            seen_d    = '0;
            partial_d = '0;
            floor_d   = '0;
          end
        end
      end else begin
        // Broken sequence: one replacement per buffered byte, then restart.
        rep       = {1'b0, seen_q};
        exp_len_d = '0;
        seen_d    = '0;
        partial_d = '0;
        floor_d   = '0;
        start_en  = 1'b1;
      end
    end else begin
      start_en = 1'b1;
    end

    // Start of a new sequence.
    if (start_en) begin
      if (byte_i[7] == 1'b0) begin
        job.data_cnt = 2'd1;
        job.data0    = {8'h00, byte_i};
      end else if ((byte_i[7:5] == 3'b110) || (byte_i[7:4] == 4'b1110) ||
                   (byte_i[7:3] == 5'b11110)) begin
        if (last_i) begin
          rep = rep + 3'd1;
        end else if (byte_i[7:5] == 3'b110) begin
          exp_len_d = 3'd2;
          seen_d    = 2'd1;
          partial_d = {16'b0, byte_i[4:0]};
          floor_d   = u2u_pkg::Floor2;
        end else if (byte_i[7:4] == 4'b1110) begin
          exp_len_d = 3'd3;
          seen_d    = 2'd1;
          partial_d = {17'b0, byte_i[3:0]};
          floor_d   = u2u_pkg::Floor3;
        end else begin
          exp_len_d = 3'd4;
          seen_d    = 2'd1;
          partial_d = {18'b0, byte_i[2:0]};
          floor_d   = u2u_pkg::Floor4;
        end
      end else begin
        rep = rep + 3'd1;
      end
    end
    job.rep_cnt = rep;
  end

  assign push_o = accept_i && ((rep != 3'd0) || (job.data_cnt != 2'd0));
  assign job_o  = job;

  // Sequence state, updated on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      seen_q    <= '0;
      partial_q <= '0;
      floor_q   <= '0;
    end else if (accept_i) begin
      exp_len_q <= exp_len_d;
      seen_q    <= seen_d;
      partial_q <= partial_d;
      floor_q   <= floor_d;
    end
  end

endmodule

// ===== hdl/u2u_fifo.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Small register queue that decouples the decoder from the unit serializer.
// ----------------------------------------------------------------------------
module u2u_fifo #(
  parameter int Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u2u_pkg::job_t         job_i,
  input  logic                  pop_i,
  output u2u_pkg::job_t         head_o,
  output u2u_pkg::fifo_status_t status_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  u2u_pkg::job_t     mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AddrW:0]    count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == (AddrW+1)'(Depth));
  assign status_o.empty = (count_q == '0);

endmodule

// ===== hdl/u2u_back.sv =====
// ----------------------------------------------------------------------------
// Code unit serializer
// Walks the job at the head of the queue one unit per cycle while the output
// register is empty or taken, and drives the registered output stream.
// ----------------------------------------------------------------------------
module u2u_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  u2u_pkg::job_t         head_i,
  input  u2u_pkg::fifo_status_t status_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [15:0]           unit_o,
  output logic                  run_last_o,
  output logic                  str_last_o
);

  logic [1:0]  pos_q, pos_d;
  logic        valid_q, valid_d;
  logic [15:0] unit_q, unit_d;
  logic        run_last_q, run_last_d;
  logic        str_last_q, str_last_d;

  logic        head_valid;
  logic        advance;
  logic [2:0]  total;
  logic        is_last;
  logic [15:0] unit;

  assign head_valid = !status_i.empty;
  assign advance    = !valid_q || ready_i;
  assign total      = head_i.rep_cnt + {1'b0, head_i.data_cnt};
  assign is_last    = (({1'b0, pos_q} + 3'd1) == total);
  assign pop_o      = head_valid && advance && is_last;

  // Pick the unit at the current position of the head job.
  always_comb begin
    if ({1'b0, pos_q} < head_i.rep_cnt) begin
      unit = u2u_pkg::ReplChar;
    end else if ({1'b0, pos_q} == head_i.rep_cnt) begin
      unit = head_i.data0;
    end else begin
      unit = head_i.data1;
    end
  end

  // Output register and position update.
  always_comb begin
    pos_d      = pos_q;
    valid_d    = valid_q;
    unit_d     = unit_q;
    run_last_d = run_last_q;
    str_last_d = str_last_q;
    if (advance) begin
      valid_d    = head_valid;
      unit_d     = unit;
      run_last_d = is_last;
      str_last_d = is_last && head_i.last;
      if (head_valid) begin
        pos_d = is_last ? 2'd0 : pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q     <= unit_d;
    run_last_q <= run_last_d;
    str_last_q <= str_last_d;
  end

  assign valid_o    = valid_q;
  assign unit_o     = unit_q;
  assign run_last_o = run_last_q;
  assign str_last_o = str_last_q;

endmodule

// ===== sim/utf8_to_utf16_transcoder_tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Streams UTF-8 bytes into the transcoder and checks every UTF-16 code unit
// it returns against a decoder model kept in a small scoreboard. Directed
// strings hit the edge cases first: extreme bytes, every sequence length,
// surrogate pairs, overlong and out-of-range sequences, encoded surrogates,
// broken continuations and truncation at string end. Mostly well-formed
// random text with malformed noise follows, under random idling on both
// sides, a long receiver hold-off and a pause until the pipeline drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_tb;

  localparam int HoldCycles   = 100;
  localparam int SettleCycles = 8;
  localparam int WatchLimit   = 2000;
  localparam int DirCount     = 25;

  // One expected code unit with its two flags.
  typedef struct packed {
    logic [15:0] unit;
    logic        run_end;
    logic        str_end;
  } utf16_unit_t;

  // Scoreboard: decodes each accepted byte into the units it must cause and
  // matches returned units against them in order.
  class utf16_scoreboard;
    // Pending sequence of the decoder model.
    logic [2:0]  pend_len    = '0;
    logic [1:0]  pend_taken  = '0;
    logic [20:0] pend_scalar = '0;
    logic [16:0] pend_floor  = '0;

    utf16_unit_t step_units[$];
    utf16_unit_t expected_units[$];

    int mismatches = 0;
    int bytes_total = 0;
    int strings_total = 0;
    int units_checked = 0;
    int repl_total = 0;
    int pairs_total = 0;

    function void add_unit(logic [15:0] u);
      utf16_unit_t e;
      e.unit = u;
      e.run_end = 1'b0;
      e.str_end = 1'b0;
      step_units.push_back(e);
      if (u == u2u_pkg::ReplChar) repl_total++;
    endfunction

    function void add_repl(int count);
      for (int i = 0; i < count; i++) add_unit(u2u_pkg::ReplChar);
    endfunction

    function void clear_seq();
      pend_len = '0;
      pend_taken = '0;
      pend_scalar = '0;
      pend_floor = '0;
    endfunction

    // A byte seen with nothing pending: ASCII, a lead byte or garbage.
    function void open_seq(logic [7:0] b);
      if (b[7] == 1'b0) begin
        add_unit({8'h00, b});
      end else if (b[7:5] == 3'b110) begin
        pend_len = 3'd2;
        pend_taken = 2'd1;
        pend_scalar = {16'h0, b[4:0]};
        pend_floor = u2u_pkg::Floor2;
      end else if (b[7:4] == 4'b1110) begin
        pend_len = 3'd3;
        pend_taken = 2'd1;
        pend_scalar = {17'h0, b[3:0]};
        pend_floor = u2u_pkg::Floor3;
      end else if (b[7:3] == 5'b11110) begin
        pend_len = 3'd4;
        pend_taken = 2'd1;
        pend_scalar = {18'h0, b[2:0]};
        pend_floor = u2u_pkg::Floor4;
      end else begin
        add_unit(u2u_pkg::ReplChar);
      end
    endfunction

    // The sequence is complete: validate the scalar and emit its units.
    function void close_seq();
      logic [20:0] offset;
      if (pend_scalar < {4'h0, pend_floor} || pend_scalar > u2u_pkg::MaxScalar ||
          (pend_scalar >= u2u_pkg::SurrLow && pend_scalar <= u2u_pkg::SurrHigh)) begin
        add_repl(int'(pend_len));
      end else if (pend_scalar < u2u_pkg::SuppBase) begin
        add_unit(pend_scalar[15:0]);
      end else begin
        offset = pend_scalar - u2u_pkg::SuppBase;
        add_unit(u2u_pkg::HighSurrBase + {6'h0, offset[19:10]});
        add_unit(u2u_pkg::LowSurrBase + {6'h0, offset[9:0]});
        pairs_total++;
      end
      clear_seq();
    endfunction

    // Note one accepted input transaction and queue the units it causes.
    function void note_byte(logic [7:0] b, logic last);
      step_units.delete();
      bytes_total++;
      if (last) strings_total++;
      if (pend_len != 0) begin
        if (b[7:6] == 2'b10) begin
          pend_scalar = {pend_scalar[14:0], b[5:0]};
          if (int'(pend_taken) + 1 >= int'(pend_len)) close_seq();
          else pend_taken = pend_taken + 2'd1;
        end else begin
          add_repl(int'(pend_taken));
          clear_seq();
          open_seq(b);
        end
      end else begin
        open_seq(b);
      end
      // Truncated sequence at string end.
      if (last && pend_len != 0) begin
        add_repl(int'(pend_taken));
        clear_seq();
      end
      if (step_units.size() > 0) begin
        step_units[step_units.size() - 1].run_end = 1'b1;
        step_units[step_units.size() - 1].str_end = last;
      end
      foreach (step_units[i]) expected_units.push_back(step_units[i]);
    endfunction

    // Check one output transaction against the oldest expected unit.
    function void check_unit(logic [15:0] unit, logic run_end, logic str_end);
      utf16_unit_t e;
      if (expected_units.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: unexpected unit %h run_end=%b str_end=%b", unit, run_end,
                   str_end);
        mismatches++;
        return;
      end
      e = expected_units.pop_front();
      units_checked++;
      if (unit !== e.unit || run_end !== e.run_end || str_end !== e.str_end) begin
        if (mismatches < 10)
          $display("ERROR: unit %0d expected %h/%b/%b, got %h/%b/%b", units_checked,
                   e.unit, e.run_end, e.str_end, unit, run_end, str_end);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_units.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  utf16_scoreboard sb;
  bit idle_on;
  bit hold_req;
  int holdoffs;
  int drains;
  logic [8:0] dir_items [DirCount];

  utf8_to_utf16_transcoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .s_axis_tlast  (s_axis_tlast),   // last_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] code_unit
    .m_axis_tuser  (m_axis_tuser),   // [0] last_of_run
    .m_axis_tlast  (m_axis_tlast)    // string_end
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: ends the run when no transaction happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WatchLimit) begin
        $display("Timeout: no transaction for %0d cycles, %0d units outstanding.",
                 WatchLimit, sb.pending());
        $display("utf8_to_utf16_transcoder_tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver: checks output transactions and drives tready with random
  // stalls and an occasional long hold-off.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_unit(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        holdoffs++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 11);
      end
    end
  end

  // Optional one-cycle sender gap after an accepted byte.
  task automatic sender_gap();
    if (idle_on && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Offer one byte and wait for the input transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, last);
    sender_gap();
  endtask

  // Stop offering until every expected unit has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    drains++;
  endtask

  // One random character: mostly well-formed, the rest overlong, surrogate,
  // out-of-range, truncated or plain noise.
  task automatic send_random_char();
    logic [20:0] cp;
    logic [7:0]  enc [4];
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    bit noise;
    bit end_str;
    pick = $urandom_range(99);
    len = $urandom_range(4, 2);
    noise = 1'b0;
    cp = '0;
    if (pick < 68) begin
      len = $urandom_range(4, 1);
      case (len)
        1: cp = 21'($urandom_range(21'h7F));
        2: cp = 21'($urandom_range(21'h7FF, 21'h80));
        3: do cp = 21'($urandom_range(21'hFFFF, 21'h800));
           while (cp >= u2u_pkg::SurrLow && cp <= u2u_pkg::SurrHigh);
        default: cp = 21'($urandom_range(u2u_pkg::MaxScalar, u2u_pkg::SuppBase));
      endcase
    end else if (pick < 76) begin
      // Overlong encoding.
      case (len)
        2: cp = 21'($urandom_range(21'h7F));
        3: cp = 21'($urandom_range(21'h7FF));
        default: cp = 21'($urandom_range(21'hFFFF));
      endcase
    end else if (pick < 81) begin
      len = 3;
      cp = 21'($urandom_range(u2u_pkg::SurrHigh, u2u_pkg::SurrLow));
    end else if (pick < 85) begin
      len = 4;
      cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
    end else if (pick < 94) begin
      // Truncated sequence; the string end or the next byte breaks it.
      cp = 21'($urandom_range(21'h1FFFFF));
    end else begin
      len = 1;
      noise = 1'b1;
    end
    keep = len;
    if (pick >= 85 && pick < 94) keep = $urandom_range(len - 1, 1);
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    if (noise) enc[0] = 8'($urandom_range(255));
    end_str = ($urandom_range(99) < 12);
    for (int i = 0; i < int'(keep); i++)
      send_byte(enc[i], end_str && (i == int'(keep) - 1));
  endtask

  // Main sequence.
  initial begin : stimulus
    sb = new();
    idle_on = 1'b1;
    hold_req = 1'b0;
    holdoffs = 0;
    drains = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    // Directed strings, {last, byte}.
    dir_items = '{
      9'h000, 9'h0FF,                        // smallest byte, invalid lead
      9'h0C3, 9'h1A9,                        // two-byte scalar
      9'h0E2, 9'h082, 9'h0AC,                // three-byte scalar
      9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,        // largest scalar, surrogate pair
      9'h0F4, 9'h090, 9'h080, 9'h080,        // above the scalar range
      9'h0C0, 9'h080,                        // overlong
      9'h0ED, 9'h0A0, 9'h080,                // encoded surrogate
      9'h0E2, 9'h082, 9'h141,                // broken continuation
      9'h0F0, 9'h19F                         // truncated at string end
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_items[i]) send_byte(dir_items[i][7:0], dir_items[i][8]);
    wait_drained();

    // Random text with idling on both sides.
    while (sb.bytes_total < DirCount + 160) send_random_char();

    // Long stretch without idling, with a receiver hold-off in the middle.
    idle_on = 1'b0;
    while (sb.bytes_total < DirCount + 200) send_random_char();
    hold_req = 1'b1;
    while (sb.bytes_total < DirCount + 300) send_random_char();
    wait_drained();

    // Idling again for the rest.
    idle_on = 1'b1;
    while (sb.bytes_total < DirCount + 435) send_random_char();

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d bytes in %0d strings; %0d units checked, %0d replacements,",
             sb.bytes_total, sb.strings_total, sb.units_checked, sb.repl_total);
    $display("%0d surrogate pairs, %0d receiver hold-offs, %0d drain pauses, %0d mismatches.",
             sb.pairs_total, holdoffs, drains, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("utf8_to_utf16_transcoder_tb: PASS");
    end else begin
      $display("utf8_to_utf16_transcoder_tb: FAIL");
    end
    $finish;
  end

endmodule
